/* sv/bqe_pkg.sv */
// Shared constants, types and helpers for the four-stage biquad equalizer.
package bqe_pkg;

  localparam int STAGES         = 4;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 23;

  localparam int IN_W       = 24;
  localparam int OUT_W      = 24;
  localparam int COEF_W     = 28;
  localparam int IDX_W      = 5;
  localparam int COEF_SLOTS = STAGES * 5;
  localparam int COEF_AW    = $clog2(COEF_SLOTS);
  localparam int STAGE_W    = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int TAP_ROW_W  = 4 * SAMPLE_BITS;
  localparam int PROD_W     = COEF_W + SAMPLE_BITS;
  localparam int ACC_W      = PROD_W + 3;
  localparam int WIDE_W     = 33;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  // One delay-line row per stage.
  typedef struct packed {
    sample_t y2;
    sample_t y1;
    sample_t x2;
    sample_t x1;
  } tap_row_t;

  typedef struct packed {
    logic init;
    logic mul_en;
    logic mul_sub;
    logic acc_en;
  } mac_ctl_t;

  function automatic sample_t clamp_in(input logic signed [IN_W-1:0] v);
    logic signed [WIDE_W-1:0] w;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    w  = WIDE_W'(v);
    hi = (WIDE_W'(1) <<< (SAMPLE_BITS - 1)) - WIDE_W'(1);
    lo = ~hi;
    if (w > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (w < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return w[SAMPLE_BITS-1:0];
  endfunction

endpackage

/* sv/bqe_if.sv */
// Request and response channel interfaces of the biquad equalizer.
interface bqe_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [bqe_pkg::IN_W-1:0]      sample_in;
  logic        [bqe_pkg::IDX_W-1:0]     coef_index;
  logic signed [bqe_pkg::COEF_W-1:0]    coef_value;

  modport source(output valid, op, sample_in, coef_index, coef_value, input ready);
  modport sink(input valid, op, sample_in, coef_index, coef_value, output ready);
endinterface

interface bqe_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bqe_pkg::OUT_W-1:0]     sample_out;
  logic                                 clipped;

  modport source(output valid, sample_out, clipped, input ready);
  modport sink(input valid, sample_out, clipped, output ready);
endinterface

/* sv/four_stage_biquad_equalizer.sv */
// Four-stage cascaded biquad equalizer: sequencer, coefficient and delay-line memories.
// A sample request runs every stage in turn on the shared multiplier, paced by the
// one-read-per-cycle coefficient memory, and its response is registered in the done state.
// A new request is taken only while the sequencer is idle; coefficient writes leave it idle.
// The next request is taken while a response waits; the sequencer stalls only at its end.
// Reset clears the valid bits of both memories: coefficients and delay line read as zero.
module four_stage_biquad_equalizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  bqe_req_if.sink   req_i,
  bqe_rsp_if.source rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] STEP_LAST  = 3'd6;
  localparam logic [5:0] SLOT_LIMIT = 6'(bqe_pkg::COEF_SLOTS);
  localparam logic [bqe_pkg::STAGE_W-1:0] STAGE_LAST = bqe_pkg::STAGE_W'(bqe_pkg::STAGES - 1);
  localparam logic [bqe_pkg::STAGE_W-1:0] STAGE_ONE  = bqe_pkg::STAGE_W'(1);
  localparam logic [bqe_pkg::COEF_AW-1:0] COEF_STRIDE = bqe_pkg::COEF_AW'(5);

  logic [1:0]                   state_q, state_d;
  logic [2:0]                   step_q, step_d;
  logic [bqe_pkg::STAGE_W-1:0]  stage_q, stage_d;
  logic [bqe_pkg::COEF_AW-1:0]  base_q, base_d;
  bqe_pkg::sample_t             x_q, x_d;
  logic                         clip_q, clip_d;
  logic                         rsp_valid_q, rsp_valid_d;
  logic [bqe_pkg::OUT_W-1:0]    out_q, out_d;
  logic                         out_clip_q, out_clip_d;

  logic                         accept;
  logic                         coef_wr;
  logic                         coef_rd;
  logic [bqe_pkg::COEF_AW-1:0]  coef_rd_addr;
  bqe_pkg::coef_t               coef_rd_data;
  logic                         tap_rd;
  logic                         tap_wr;
  bqe_pkg::tap_row_t            tap_rd_data;
  bqe_pkg::tap_row_t            tap_wr_data;
  bqe_pkg::mac_ctl_t            mac_ctl;
  bqe_pkg::sample_t             opnd;
  bqe_pkg::sample_t             y;
  logic                         y_sat;
  logic signed [bqe_pkg::WIDE_W-1:0] x_wide;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign coef_wr     = accept && (req_i.op == bqe_pkg::OP_COEF)
                       && ({1'b0, req_i.coef_index} < SLOT_LIMIT);

  assign coef_rd      = (state_q == ST_RUN) && (step_q < 3'd5);
  assign coef_rd_addr = base_q + bqe_pkg::COEF_AW'(step_q);
  assign tap_rd       = (state_q == ST_RUN) && (step_q == 3'd0);
  assign tap_wr       = (state_q == ST_RUN) && (step_q == STEP_LAST);

  always_comb begin
    tap_wr_data.x1 = x_q;
    tap_wr_data.x2 = tap_rd_data.x1;
    tap_wr_data.y1 = y;
    tap_wr_data.y2 = tap_rd_data.y1;
  end

  always_comb begin
    mac_ctl.init    = tap_rd;
    mac_ctl.mul_en  = (state_q == ST_RUN) && (step_q inside {[3'd1:3'd5]});
    mac_ctl.mul_sub = step_q inside {3'd4, 3'd5};
    mac_ctl.acc_en  = (state_q == ST_RUN) && (step_q inside {[3'd2:3'd5]});
  end

  always_comb begin
    case (step_q)
      3'd2:    opnd = tap_rd_data.x1;
      3'd3:    opnd = tap_rd_data.x2;
      3'd4:    opnd = tap_rd_data.y1;
      3'd5:    opnd = tap_rd_data.y2;
      default: opnd = x_q;
    endcase
  end

  assign x_wide = bqe_pkg::WIDE_W'(x_q);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    stage_d     = stage_q;
    base_d      = base_q;
    x_d         = x_q;
    clip_d      = clip_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    out_d       = out_q;
    out_clip_d  = out_clip_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.op == bqe_pkg::OP_SAMPLE)) begin
          state_d = ST_RUN;
          step_d  = 3'd0;
          stage_d = '0;
          base_d  = '0;
          x_d     = bqe_pkg::clamp_in(req_i.sample_in);
          clip_d  = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_LAST) begin
          x_d    = y;
          clip_d = clip_q | y_sat;
          step_d = 3'd0;
          if (stage_q == STAGE_LAST) begin
            state_d = ST_DONE;
          end else begin
            stage_d = stage_q + STAGE_ONE;
            base_d  = base_q + COEF_STRIDE;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          out_d       = x_wide[bqe_pkg::OUT_W-1:0];
          out_clip_d  = clip_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 3'd0;
      stage_q     <= '0;
      base_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      stage_q     <= stage_d;
      base_q      <= base_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    clip_q     <= clip_d;
    out_q      <= out_d;
    out_clip_q <= out_clip_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.sample_out = out_q;
  assign rsp_o.clipped    = out_clip_q;

  bqe_ram #(
    .DEPTH(bqe_pkg::COEF_SLOTS),
    .WIDTH(bqe_pkg::COEF_W)
  ) u_coef_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (coef_wr),
    .wr_addr_i (bqe_pkg::COEF_AW'(req_i.coef_index)),
    .wr_data_i (req_i.coef_value),
    .rd_en_i   (coef_rd),
    .rd_addr_i (coef_rd_addr),
    .rd_data_o (coef_rd_data)
  );

  bqe_ram #(
    .DEPTH(bqe_pkg::STAGES),
    .WIDTH(bqe_pkg::TAP_ROW_W)
  ) u_tap_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tap_wr),
    .wr_addr_i (stage_q),
    .wr_data_i (tap_wr_data),
    .rd_en_i   (tap_rd),
    .rd_addr_i (stage_q),
    .rd_data_o (tap_rd_data)
  );

  bqe_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .coef_i (coef_rd_data),
    .opnd_i (opnd),
    .y_o    (y),
    .sat_o  (y_sat)
  );

`ifndef SYNTH
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_LAST))
    else $error("step counter out of range");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (stage_q <= STAGE_LAST))
    else $error("stage counter out of range");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.op == bqe_pkg::OP_SAMPLE)) |=> (state_q == ST_RUN) && (step_q == 3'd0))
    else $error("sample request did not start the sequencer");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("response raised outside the done state");

  a_coef_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_wr |-> !coef_rd && !tap_wr)
    else $error("coefficient write overlaps filtering");
`endif

endmodule

/* sv/bqe_ram.sv */
// Single-port-write, registered-read RAM whose entries read as zero until written.
module bqe_ram #(
  parameter int  DEPTH = 2,
  parameter int  WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

/* sv/bqe_mac.sv */
// Shared multiply-accumulate with rounding and saturation of the stage output.
module bqe_mac (
  input  logic              clk_i,
  input  bqe_pkg::mac_ctl_t ctl_i,
  input  bqe_pkg::coef_t    coef_i,
  input  bqe_pkg::sample_t  opnd_i,
  output bqe_pkg::sample_t  y_o,
  output logic              sat_o
);

  localparam logic signed [bqe_pkg::ACC_W-1:0] ROUND =
    bqe_pkg::ACC_W'(1) <<< (bqe_pkg::COEF_FRAC_BITS - 1);
  localparam logic signed [bqe_pkg::ACC_W-1:0] HI =
    (bqe_pkg::ACC_W'(1) <<< (bqe_pkg::SAMPLE_BITS - 1)) - bqe_pkg::ACC_W'(1);
  localparam logic signed [bqe_pkg::ACC_W-1:0] LO = ~HI;

  logic signed [bqe_pkg::PROD_W-1:0] prod_d;
  logic signed [bqe_pkg::PROD_W-1:0] prod_q;
  logic                              sub_q;
  logic signed [bqe_pkg::ACC_W-1:0]  acc_q;
  logic signed [bqe_pkg::ACC_W-1:0]  term;
  logic signed [bqe_pkg::ACC_W-1:0]  sum;
  logic signed [bqe_pkg::ACC_W-1:0]  shifted;

  assign prod_d = bqe_pkg::PROD_W'(coef_i) * bqe_pkg::PROD_W'(opnd_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
      sub_q  <= ctl_i.mul_sub;
    end
    if (ctl_i.init) begin
      acc_q <= ROUND;
    end else if (ctl_i.acc_en) begin
      acc_q <= sum;
    end
  end

  assign term    = sub_q ? -bqe_pkg::ACC_W'(prod_q) : bqe_pkg::ACC_W'(prod_q);
  assign sum     = acc_q + term;
  assign shifted = sum >>> bqe_pkg::COEF_FRAC_BITS;

  always_comb begin
    sat_o = 1'b1;
    if (shifted > HI) begin
      y_o = HI[bqe_pkg::SAMPLE_BITS-1:0];
    end else if (shifted < LO) begin
      y_o = LO[bqe_pkg::SAMPLE_BITS-1:0];
    end else begin
      y_o   = shifted[bqe_pkg::SAMPLE_BITS-1:0];
      sat_o = 1'b0;
    end
  end

endmodule

/* verif/four_stage_biquad_equalizer_checker.sv */
`timescale 1ns / 1ps
// Response checker for the biquad equalizer: mirrors coefficients and delay line, checks outputs.
module biquad_output_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bqe_req_if   req_i,
  bqe_rsp_if   rsp_i,
  output int   mismatches_o,
  output int   pending_o
);
  import bqe_pkg::*;

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int     MAX_REPORTS = 40;

  typedef struct packed {
    sample_t value;
    logic    clip;
  } eq_out_t;

  coef_t    coefs [COEF_SLOTS];
  tap_row_t taps [STAGES];
  eq_out_t  expected_outputs [$];
  int       mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Runs one sample through the cascade and advances the delay line.
  function automatic eq_out_t run_filter_chain(input sample_t x_in);
    eq_out_t res;
    sample_t x;
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
    longint  hist [5];
    longint  acc;
    longint  y;
    res.clip = 1'b0;
    x = x_in;
    for (int s = 0; s < STAGES; s++) begin
      x1 = taps[s].x1;
      x2 = taps[s].x2;
      y1 = taps[s].y1;
      y2 = taps[s].y2;
      // feedback taps enter negated so one sum covers all five products
      hist[0] = longint'(x);
      hist[1] = longint'(x1);
      hist[2] = longint'(x2);
      hist[3] = -longint'(y1);
      hist[4] = -longint'(y2);
      acc = 0;
      for (int k = 0; k < 5; k++) begin
        acc += longint'(coefs[5*s + k]) * hist[k];
      end
      acc += longint'(1) <<< (COEF_FRAC_BITS - 1);
      y = acc >>> COEF_FRAC_BITS;
      if (y > SAT_HI) begin
        y = SAT_HI;
        res.clip = 1'b1;
      end else if (y < SAT_LO) begin
        y = SAT_LO;
        res.clip = 1'b1;
      end
      taps[s].x2 = x1;
      taps[s].x1 = x;
      taps[s].y2 = y1;
      taps[s].y1 = sample_t'(y);
      x = sample_t'(y);
    end
    res.value = x;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    eq_out_t want;
    if (!rst_ni) begin
      foreach (coefs[i]) coefs[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      expected_outputs.delete();
      mismatches = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("response with nothing outstanding, sample_out=%0d",
                                    rsp_i.sample_out));
        end else begin
          want = expected_outputs.pop_front();
          if (rsp_i.sample_out !== want.value) begin
            report_mismatch($sformatf("sample_out got %0d want %0d",
                                      rsp_i.sample_out, want.value));
          end
          if (rsp_i.clipped !== want.clip) begin
            report_mismatch($sformatf("clipped got %b want %b (sample_out %0d)",
                                      rsp_i.clipped, want.clip, want.value));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.op == OP_SAMPLE) begin
          expected_outputs.push_back(run_filter_chain(sample_t'(req_i.sample_in)));
        end else if (req_i.coef_index < COEF_SLOTS) begin
          coefs[req_i.coef_index] = req_i.coef_value;
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_outputs.size();
  end

endmodule

/* verif/four_stage_biquad_equalizer_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the biquad equalizer: clock, reset, request traffic, backpressure and verdict.
module four_stage_biquad_equalizer_tb;
  import bqe_pkg::*;

  localparam int NUM_ITEMS       = 1600;
  localparam int QUIET_ITEMS     = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 2500;
  localparam int DRAIN_CYCLES    = 64;
  localparam int ONE             = 1 << COEF_FRAC_BITS;

  localparam coef_t   COEF_UNITY = coef_t'(ONE);
  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {KIND_B0, KIND_B1, KIND_B2, KIND_A1, KIND_A2, KIND_COUNT} coef_kind_e;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  logic long_hold_go;
  int   mismatches;
  int   pending;
  int   counted;
  int   idle_cycles = 0;

  bqe_req_if req ();
  bqe_rsp_if rsp ();

  four_stage_biquad_equalizer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  biquad_output_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_i       (rsp),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic coef_t tame_coef(input int kind);
    int span;
    span = (kind == KIND_A1) ? ONE / 2 : (kind == KIND_A2) ? ONE / 4 : ONE;
    return coef_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3: return tame_coef(KIND_B0);
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offers one request and returns at the edge that takes it; may idle afterwards.
  task automatic send(input logic op, input sample_t smp, input logic [IDX_W-1:0] idx,
                      input coef_t val);
    req.valid      <= 1'b1;
    req.op         <= op;
    req.sample_in  <= smp;
    req.coef_index <= idx;
    req.coef_value <= val;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    if (op == OP_SAMPLE || idx < COEF_SLOTS) counted++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic write_coef(input logic [IDX_W-1:0] idx, input coef_t val);
    send(OP_COEF, sample_t'($urandom), idx, val);
  endtask

  task automatic filter(input sample_t smp);
    send(OP_SAMPLE, smp, IDX_W'($urandom), coef_t'($urandom));
  endtask

  task automatic load_coef_set(input bit tame);
    for (int s = 0; s < STAGES; s++) begin
      for (int k = KIND_B0; k < KIND_COUNT; k++) begin
        write_coef(IDX_W'(5*s + k), tame ? tame_coef(k) : rand_coef());
      end
    end
  endtask

  // response side: short random stalls, one long hold-off
  initial begin : rsp_side
    int stall;
    int hold;
    bit hold_done;
    stall     = 0;
    hold      = 0;
    hold_done = 0;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_go && !hold_done) begin
        hold      = HOLD_OFF_CYCLES;
        hold_done = 1;
      end
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int pick;
    counted         = 0;
    rst_ni          <= 1'b0;
    quiet           <= 1'b0;
    long_hold_go    <= 1'b0;
    req.valid       <= 1'b0;
    req.op          <= OP_SAMPLE;
    req.sample_in   <= '0;
    req.coef_index  <= '0;
    req.coef_value  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero table gives silence
    filter(SAMPLE_MAX);
    // unity pass-through
    for (int s = 0; s < STAGES; s++) write_coef(IDX_W'(5*s + KIND_B0), COEF_UNITY);
    filter(SAMPLE_MAX);
    filter(SAMPLE_MIN);
    filter('0);
    filter('1);
    // slots past the table are dropped
    write_coef(IDX_W'(COEF_SLOTS), COEF_MAX);
    write_coef('1, COEF_MIN);
    // full-scale gain saturates in both directions
    write_coef(IDX_W'(KIND_B0), COEF_MAX);
    filter(SAMPLE_MAX);
    filter(SAMPLE_MIN);
    write_coef(IDX_W'(KIND_B0), COEF_MIN);
    filter(SAMPLE_MAX);
    filter(SAMPLE_MIN);
    write_coef(IDX_W'(KIND_A1), COEF_MIN);
    write_coef(IDX_W'(KIND_A2), COEF_MAX);
    filter(SAMPLE_MAX);
    filter(sample_t'(1));
    filter('0);

    long_hold_go <= 1'b1;
    load_coef_set(1'b1);
    while (counted < NUM_ITEMS) begin
      if (counted >= NUM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
      pick = $urandom_range(0, 199);
      if (pick < 2) begin
        load_coef_set($urandom_range(0, 3) != 0);
      end else if (pick < 14) begin
        write_coef(IDX_W'($urandom), rand_coef());
      end else begin
        filter(rand_sample());
      end
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bqe_pkg.sv
sv/bqe_if.sv
sv/bqe_ram.sv
sv/bqe_mac.sv
sv/four_stage_biquad_equalizer.sv
verif/four_stage_biquad_equalizer_checker.sv
verif/four_stage_biquad_equalizer_tb.sv
